// File: rtl/core/btl_pkg.sv
// btl_pkg: shared types and constants for the binary paper-tape loader
`default_nettype none

package btl_pkg;

  // tape codes
  localparam logic [7:0] RUBOUT_CODE  = 8'o377;
  localparam logic [7:0] TRAILER_CODE = 8'o200;
  localparam logic [7:0] FIELD_MASK   = 8'o070;
  localparam logic [11:0] WORD_MASK   = 12'o7777;

  // result kinds
  typedef enum logic [2:0] {
    KIND_WRITE   = 3'd0,
    KIND_OK      = 3'd1,
    KIND_BADSUM  = 3'd2,
    KIND_TRUNC   = 3'd3,
    KIND_NOSEC   = 3'd4,
    KIND_DONE    = 3'd5
  } kind_t;

  // reader phase, one-hot
  typedef enum logic [2:0] {
    PH_LEADER = 3'b001,
    PH_LOW    = 3'b010,
    PH_HIGH   = 3'b100
  } phase_t;

  typedef struct packed {
    logic [7:0] tape_byte;
    logic       end_of_tape;
  } in_item_t;

  typedef struct packed {
    logic [2:0]  kind;
    logic [14:0] address;
    logic [11:0] data;
  } out_item_t;

endpackage

`default_nettype wire

// File: rtl/core/bin_tape_loader.sv
// bin_tape_loader: binary paper-tape word assembler with checksum and output register
//
// Usage: one tape byte per input transaction on in_valid/in_stall/in_data,
// with end_of_tape flagging that the tape has run out. Results leave on
// out_valid/out_stall/out_data: memory writes (field*4096 + origin, 12-bit
// data) and section/tape status codes. Each input transaction gives zero
// or one result.
// A result is in the output register in the cycle after the byte
// that causes it is taken (a write appears once the following byte is
// known). Throughput: one byte per cycle unless the receiver stalls, set by
// the single pass from the loader state registers into the output register.
// Reset (rst_n low, synchronous) returns the reader to leader search,
// clears the origin, field, checksum and rubout state, and empties the
// output register.
// When the receiver stalls with a result held, in_stall rises and no byte
// is taken; a byte is still taken in the cycle the held result leaves.
// After a checksum error or the end of the tape the loader ignores all
// further bytes until reset.
`default_nettype none

module bin_tape_loader (
  input  wire logic               clk,
  input  wire logic               rst_n,
  input  wire logic               in_valid,
  output logic                    in_stall,
  input  wire btl_pkg::in_item_t  in_data,
  output logic                    out_valid,
  input  wire logic               out_stall,
  output btl_pkg::out_item_t      out_data
);
  import btl_pkg::*;

  phase_t      phase_r, phase_nxt;
  logic        stopped_r, stopped_nxt;
  logic        rubout_r, rubout_nxt;
  logic [6:0]  high_frame_r, high_frame_nxt;
  logic [6:0]  held_high_r, held_high_nxt;
  logic [7:0]  held_low_r, held_low_nxt;
  logic [12:0] held_word_r, held_word_nxt;
  logic [11:0] frame_sum_r, frame_sum_nxt;
  logic [11:0] origin_r, origin_nxt;
  logic [2:0]  cur_field_r, cur_field_nxt;
  logic [2:0]  next_field_r, next_field_nxt;
  logic        any_section_r, any_section_nxt;

  logic        out_valid_r, out_valid_nxt;
  out_item_t   out_data_r;

  logic        in_acc;
  logic        res_vld;
  out_item_t   res;
  logic [7:0]  c;
  logic [11:0] sum_add;

  // a byte is taken unless a result is held and the receiver stalls
  assign in_stall  = out_valid_r & out_stall;
  assign in_acc    = in_valid & ~in_stall;
  assign c         = in_data.tape_byte;
  assign sum_add   = frame_sum_r + {5'd0, held_high_r} + {4'd0, held_low_r};
  assign out_valid = out_valid_r;
  assign out_data  = out_data_r;

  // loader step for one byte
  always_comb begin
    phase_nxt       = phase_r;
    stopped_nxt     = stopped_r;
    rubout_nxt      = rubout_r;
    high_frame_nxt  = high_frame_r;
    held_high_nxt   = held_high_r;
    held_low_nxt    = held_low_r;
    held_word_nxt   = held_word_r;
    frame_sum_nxt   = frame_sum_r;
    origin_nxt      = origin_r;
    cur_field_nxt   = cur_field_r;
    next_field_nxt  = next_field_r;
    any_section_nxt = any_section_r;
    res_vld         = 1'b0;
    res             = '0;

    if (stopped_r) begin
      // ignore everything until reset
    end else if (in_data.end_of_tape) begin
      stopped_nxt = 1'b1;
      res_vld     = 1'b1;
      if (phase_r == PH_LOW || phase_r == PH_HIGH) begin
        res.kind = KIND_TRUNC;
      end else begin
        res.kind = any_section_r ? KIND_DONE : KIND_NOSEC;
      end
    end else if (rubout_r) begin
      rubout_nxt = 1'b0;
    end else if (c == RUBOUT_CODE) begin
      rubout_nxt = 1'b1;
    end else if (c > TRAILER_CODE) begin
      next_field_nxt = c[5:3];
    end else begin
      unique case (phase_r)
        PH_LOW: begin
          held_high_nxt = high_frame_r;
          held_low_nxt  = c;
          held_word_nxt = {high_frame_r, 6'd0} | {5'd0, c};
          phase_nxt     = PH_HIGH;
        end
        PH_HIGH: begin
          if (c == TRAILER_CODE) begin
            res_vld = 1'b1;
            if (frame_sum_r != held_word_r[11:0]) begin
              stopped_nxt = 1'b1;
              res.kind    = KIND_BADSUM;
            end else begin
              res.kind        = KIND_OK;
              any_section_nxt = 1'b1;
              frame_sum_nxt   = '0;
              origin_nxt      = '0;
              cur_field_nxt   = '0;
              next_field_nxt  = '0;
              phase_nxt       = PH_LEADER;
            end
          end else begin
            frame_sum_nxt = sum_add;
            if (held_word_r[12]) begin
              origin_nxt = held_word_r[11:0];
            end else begin
              res_vld     = 1'b1;
              res.kind    = KIND_WRITE;
              res.address = {cur_field_r, origin_r};
              res.data    = held_word_r[11:0];
              origin_nxt  = origin_r + 12'd1;
            end
            cur_field_nxt  = next_field_r;
            high_frame_nxt = c[6:0];
            phase_nxt      = PH_LOW;
          end
        end
        default: begin
          // leader: skip blank and trailer codes
          phase_nxt = PH_LEADER;
          if (c != 8'd0 && c < TRAILER_CODE) begin
            high_frame_nxt = c[6:0];
            phase_nxt      = PH_LOW;
          end
        end
      endcase
    end
  end

  // output register occupancy
  always_comb begin
    out_valid_nxt = out_valid_r & out_stall;
    if (in_acc && res_vld) begin
      out_valid_nxt = 1'b1;
    end
  end

  // control and loader state
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      phase_r       <= PH_LEADER;
      stopped_r     <= 1'b0;
      rubout_r      <= 1'b0;
      high_frame_r  <= '0;
      held_high_r   <= '0;
      held_low_r    <= '0;
      held_word_r   <= '0;
      frame_sum_r   <= '0;
      origin_r      <= '0;
      cur_field_r   <= '0;
      next_field_r  <= '0;
      any_section_r <= 1'b0;
      out_valid_r   <= 1'b0;
    end else begin
      out_valid_r <= out_valid_nxt;
      if (in_acc) begin
        phase_r       <= phase_nxt;
        stopped_r     <= stopped_nxt;
        rubout_r      <= rubout_nxt;
        high_frame_r  <= high_frame_nxt;
        held_high_r   <= held_high_nxt;
        held_low_r    <= held_low_nxt;
        held_word_r   <= held_word_nxt;
        frame_sum_r   <= frame_sum_nxt;
        origin_r      <= origin_nxt;
        cur_field_r   <= cur_field_nxt;
        next_field_r  <= next_field_nxt;
        any_section_r <= any_section_nxt;
      end
    end
  end

  // result payload
  always_ff @(posedge clk) begin
    if (in_acc && res_vld) begin
      out_data_r <= res;
    end
  end

  // checks
  ap_stall_only_full: assert property (@(posedge clk) disable iff (!rst_n)
    in_stall |-> out_valid_r)
    else $error("input stalled with empty output register");

  ap_stop_sticky: assert property (@(posedge clk) disable iff (!rst_n)
    stopped_r |=> stopped_r)
    else $error("stopped loader restarted without reset");

  ap_stopped_silent: assert property (@(posedge clk) disable iff (!rst_n)
    (stopped_r && in_acc) |=> (out_valid_r == $past(out_valid_r && out_stall)))
    else $error("stopped loader produced a result");

  ap_status_zero: assert property (@(posedge clk) disable iff (!rst_n)
    (out_valid_r && out_data_r.kind != KIND_WRITE) |->
      (out_data_r.address == '0 && out_data_r.data == '0))
    else $error("status result carries address or data");

  ap_phase_onehot: assert property (@(posedge clk) disable iff (!rst_n)
    $onehot(phase_r))
    else $error("reader phase lost one-hot coding");

endmodule

`default_nettype wire
